// ===== rtl/wlpf_pkg.sv =====
package wlpf_pkg;

  localparam int SCREEN_WIDTH  = 160;
  localparam int SCREEN_HEIGHT = 144;
  localparam int RAM_DEPTH     = 8192;

  localparam int RAM_AW  = $clog2(RAM_DEPTH);
  localparam int BANK_DEPTH = RAM_DEPTH / 2;
  localparam int BANK_AW = $clog2(BANK_DEPTH);

  localparam logic [8:0] WIN_X_LIMIT = 9'd166;
  localparam logic [8:0] WIN_X_SHIFT = 9'd7;

  localparam int LCDC_BG_EN    = 0;
  localparam int LCDC_UNSIGNED = 4;
  localparam int LCDC_WIN_EN   = 5;
  localparam int LCDC_MAP_SEL  = 6;

  localparam logic [1:0] MAP_PREFIX = 2'b11;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    REG_LCD_CONTROL = 2'd0,
    REG_WINDOW_X    = 2'd1,
    REG_WINDOW_Y    = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic              valid;
    logic              kind;
    logic              covered;
    logic              unsigned_data;
    logic [7:0]        win_col;
    logic [7:0]        win_row;
    logic [RAM_AW-1:0] map_addr;
    logic [RAM_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
  } locate_t;

endpackage

// ===== rtl/wlpf_ram.sv =====
module wlpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old data on a same-address write
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/wlpf_locate.sv =====
module wlpf_locate import wlpf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic              kind,
  input  logic [RAM_AW-1:0] ram_address,
  input  logic [7:0]        ram_data,
  input  logic [7:0]        screen_x,
  input  logic [7:0]        screen_y,
  input  logic [7:0]        lcd_control,
  input  logic [7:0]        window_x,
  input  logic [7:0]        window_y,
  output locate_t           loc
);

  localparam logic [8:0] WIDTH_LIM  = 9'(SCREEN_WIDTH);
  localparam logic [8:0] HEIGHT_LIM = 9'(SCREEN_HEIGHT);

  logic [8:0] x_shift;
  logic [7:0] col;
  logic [7:0] row;
  logic       cov;

  always_comb begin
    x_shift = {1'b0, screen_x} + WIN_X_SHIFT;
    col     = 8'(x_shift - {1'b0, window_x});
    row     = screen_y - window_y;
    cov     = (kind == KIND_QUERY)
              && lcd_control[LCDC_BG_EN] && lcd_control[LCDC_WIN_EN]
              && ({1'b0, window_x} <= WIN_X_LIMIT)
              && ({1'b0, window_y} < HEIGHT_LIM)
              && ({1'b0, screen_x} < WIDTH_LIM)
              && ({1'b0, screen_y} < HEIGHT_LIM)
              && (x_shift >= {1'b0, window_x})
              && (screen_y >= window_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loc.valid <= 1'b0;
    end else if (en) begin
      loc.valid <= in_valid;
    end
    if (en) begin
      loc.kind          <= kind;
      loc.covered       <= cov;
      loc.unsigned_data <= lcd_control[LCDC_UNSIGNED];
      loc.win_col       <= col;
      loc.win_row       <= row;
      loc.map_addr      <= {MAP_PREFIX, lcd_control[LCDC_MAP_SEL], row[7:3], col[7:3]};
      loc.wr_addr       <= ram_address;
      loc.wr_data       <= ram_data;
    end
  end

endmodule

// ===== rtl/wlpf_fetch.sv =====
module wlpf_fetch import wlpf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  locate_t    loc,
  output logic       out_valid,
  output logic       out_covered,
  output logic [1:0] out_color
);

  logic       wr_en;
  logic [7:0] tile;
  logic [7:0] plane_lo;
  logic [7:0] plane_hi;

  logic       v2, cov2, uns2;
  logic [2:0] bit2, line2;
  logic       v3, cov3;
  logic [2:0] bit3, sel3;
  logic [BANK_AW-1:0] bank_addr;

  assign wr_en = en && loc.valid && (loc.kind == KIND_WRITE);

  wlpf_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_map_ram (
    .clk   (clk),
    .en    (en),
    .we    (wr_en),
    .waddr (loc.wr_addr),
    .wdata (loc.wr_data),
    .raddr (loc.map_addr),
    .rdata (tile)
  );

  // tile line address, bit 11 set only for signed tiles 0..127
  assign bank_addr = {~uns2 & ~tile[7], tile, line2};

  wlpf_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_lo_ram (
    .clk   (clk),
    .en    (en),
    .we    (wr_en && !loc.wr_addr[0]),
    .waddr (loc.wr_addr[RAM_AW-1:1]),
    .wdata (loc.wr_data),
    .raddr (bank_addr),
    .rdata (plane_lo)
  );

  wlpf_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_hi_ram (
    .clk   (clk),
    .en    (en),
    .we    (wr_en && loc.wr_addr[0]),
    .waddr (loc.wr_addr[RAM_AW-1:1]),
    .wdata (loc.wr_data),
    .raddr (bank_addr),
    .rdata (plane_hi)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v2        <= loc.valid;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  assign sel3 = 3'd7 - bit3;

  always_ff @(posedge clk) begin
    if (en) begin
      cov2        <= loc.covered;
      uns2        <= loc.unsigned_data;
      bit2        <= loc.win_col[2:0];
      line2       <= loc.win_row[2:0];
      cov3        <= cov2;
      bit3        <= bit2;
      out_covered <= cov3;
      out_color   <= cov3 ? {plane_hi[sel3], plane_lo[sel3]} : 2'b00;
    end
  end

endmodule

// ===== rtl/window_layer_pixel_fetch_unit.sv =====
// Window layer pixel fetch. Write items (tuser 0) store one byte into the 8 KiB
// video RAM; query items (tuser 1) return whether the window covers the pixel and
// its 2-bit color, read from the selected 32x32 map and the tile's plane bytes.
// One item is accepted per clock unless m_tready stalls; each gives one result.
// The path is locate, map read, plane read, color select; the plane bytes come
// from even/odd banks, read at once. A write lands before any later query reads.
// Users must write registers over APB only while idle; not enforced by the block.
module window_layer_pixel_fetch_unit import wlpf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [12:0] ram_address, [20:13] ram_data, [28:21] screen_x, [36:29] screen_y
  input  logic [39:0] s_tdata,
  // [0] kind
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] covered, [2:1] color_index
  output logic [7:0]  m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       en;
  logic       cfg_wr;
  logic [7:0] lcd_control;
  logic [7:0] window_x;
  logic [7:0] window_y;
  logic       out_covered;
  logic [1:0] out_color;
  reg_index_t reg_idx;
  locate_t    loc;

  assign pready  = 1'b1;
  assign reg_idx = reg_index_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_control <= 8'd0;
      window_x    <= 8'd0;
      window_y    <= 8'd0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LCD_CONTROL: lcd_control <= pwdata[7:0];
        REG_WINDOW_X:    window_x    <= pwdata[7:0];
        REG_WINDOW_Y:    window_y    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LCD_CONTROL: prdata = {24'd0, lcd_control};
      REG_WINDOW_X:    prdata = {24'd0, window_x};
      REG_WINDOW_Y:    prdata = {24'd0, window_y};
      default:         prdata = 32'd0;
    endcase
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  wlpf_locate u_locate (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (s_tvalid),
    .kind        (s_tuser),
    .ram_address (s_tdata[12:0]),
    .ram_data    (s_tdata[20:13]),
    .screen_x    (s_tdata[28:21]),
    .screen_y    (s_tdata[36:29]),
    .lcd_control (lcd_control),
    .window_x    (window_x),
    .window_y    (window_y),
    .loc         (loc)
  );

  wlpf_fetch u_fetch (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .loc         (loc),
    .out_valid   (m_tvalid),
    .out_covered (out_covered),
    .out_color   (out_color)
  );

  assign m_tdata = {5'd0, out_color, out_covered};

  a_color_needs_cover: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[2:1] == 2'b00)
    else $error("color set on uncovered result");

  a_cover_needs_enable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> lcd_control[LCDC_BG_EN] && lcd_control[LCDC_WIN_EN])
    else $error("covered result with window disabled");

  a_write_not_covered: assert property (@(posedge clk) disable iff (rst)
    loc.valid && loc.kind == KIND_WRITE |-> !loc.covered)
    else $error("write item marked covered");

endmodule
